// File: src/utt_pkg.sv
// ----------------------------------------------------------------------------
// utt_pkg: shared types and codes of the sorted uid-to-tos table
// status codes, action codes, register indices and the sequencer state
// ----------------------------------------------------------------------------
package utt_pkg;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_ADD    = 2'd1,
		ACT_DELETE = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_FULL    = 3'd2,
		ST_DUP     = 3'd3,
		ST_MISSING = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MOD,
		S_SEARCH,
		S_DECIDE,
		S_SHIFT,
		S_WRITE,
		S_OUT
	} state_t;

	localparam int unsigned REG_APP_BASE  = 0;
	localparam int unsigned REG_RANGE     = 1;
	localparam int unsigned REG_SYS_TOS   = 2;

endpackage

// File: src/utt_mod.sv
// ----------------------------------------------------------------------------
// utt_mod: multi-cycle unsigned remainder
// restoring division, one quotient bit per cycle, zero modulus passes through
// ----------------------------------------------------------------------------
module utt_mod
	import utt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic        done,
	output logic [31:0] remainder
);

	logic [32:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= (divisor != '0);
				done   <= (divisor == '0);
				cnt_q  <= 6'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (!trial[32]) rem_q <= trial;
			else rem_q <= {rem_q[31:0], quo_q[31]};
		end
	end

	assign remainder = (div_q == '0) ? quo_q : rem_q[31:0];

endmodule

// File: src/utt_ram.sv
// ----------------------------------------------------------------------------
// utt_ram: entry memory holding key and tos per slot
// one write port, one registered read port
// ----------------------------------------------------------------------------
module utt_ram
	import utt_pkg::*;
#(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [39:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [39:0]   rdata
);

	logic [39:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// File: src/uid_to_tos_sorted_table_top.sv
// ----------------------------------------------------------------------------
// uid_to_tos_sorted_table_top: sorted id table with type-of-service bytes
// lookup, add, delete and clear over a memory kept in ascending key order
// ----------------------------------------------------------------------------
// channel   | dir | fields
// s_axis    | in  | tdata: action[1:0], raw_id[33:2], tos_value[41:34]
// m_axis    | out | tdata: status[2:0], tos_hit[3], tos_out[11:4]
// cfg       | in  | wr_en, wr_index, wr_data
//
// an item passes through the remainder unit (a zero modulus goes straight
// through), a scan that reads and compares each stored entry below the id,
// a decide step and, for an add or delete that changes the table, a shift
// of the entries from the slot upward and a write step, then an output step;
// each scan and shift step waits on the registered memory read
// reset clears the entry count, so no clearing pass is needed
// one item is in work at a time; a finished result waits in the output
// register, so the next transaction is taken while it waits, and the sequencer
// holds at its output step only while an earlier result is still untaken
module uid_to_tos_sorted_table_top
	import utt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // action, raw_id, tos_value, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // status, tos_hit, tos_out, zero fill
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_DEPTH);

	// configuration
	logic [31:0] app_base_q, range_q;
	logic [7:0]  sys_tos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			app_base_q <= 32'd10000;
			range_q    <= 32'd100000;
			sys_tos_q  <= 8'd0;
		end else if (wr_en) begin
			case (wr_index)
				2'(REG_APP_BASE): app_base_q <= wr_data;
				2'(REG_RANGE):    range_q    <= wr_data;
				2'(REG_SYS_TOS):  sys_tos_q  <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	state_t      state_q, state_d;
	action_t     act_q;
	logic [31:0] id_q;
	logic [7:0]  tos_in_q;
	logic [CW-1:0] cnt_q;      // valid entries
	logic [CW-1:0] idx_q;      // scan / shift pointer
	logic [CW-1:0] pos_q;      // lower bound result
	logic        rd_pend_q;    // memory read issued last cycle
	logic        found_q;
	logic [7:0]  hit_tos_q;
	logic [2:0]  st_q;
	logic        hit_q;
	logic [7:0]  tout_q;
	logic [11:0] res_q;        // result transaction waiting on m_axis
	logic        out_v_q;

	logic        mod_start, mod_done;
	logic [31:0] mod_rem;

	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [39:0]   ram_wdata, ram_rdata;

	utt_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (mod_start),
		.dividend  (s_axis_tdata[33:2]),
		.divisor   (range_q),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	utt_ram #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// input taken whenever the sequencer is idle
	assign s_axis_tready = (state_q == S_IDLE);
	logic s_fire;
	assign s_fire    = s_axis_tvalid && s_axis_tready;
	assign mod_start = s_fire;

	// output register free, or emptied at this edge
	logic m_fire, out_free;
	assign m_fire   = m_axis_tvalid && m_axis_tready;
	assign out_free = !out_v_q || m_axis_tready;

	// scan: read entry idx, compare in the next cycle
	logic scan_end;
	logic key_ge;
	assign key_ge   = rd_pend_q && (ram_rdata[31:0] >= id_q);
	assign scan_end = key_ge || (!rd_pend_q && idx_q >= cnt_q);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (s_fire) state_d = S_MOD;
			S_MOD:    if (mod_done) state_d = S_SEARCH;
			S_SEARCH: if (scan_end) state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = S_OUT;
				if (act_q == ACT_ADD && id_q >= app_base_q && cnt_q < FULL_CNT && !found_q)
					state_d = S_SHIFT;
				if (act_q == ACT_DELETE && id_q >= app_base_q && found_q)
					state_d = S_SHIFT;
			end
			S_SHIFT: begin
				if (act_q == ACT_ADD) begin
					if (idx_q == pos_q && !rd_pend_q) state_d = S_WRITE;
				end else if (idx_q + CW'(1) >= cnt_q && !rd_pend_q) begin
					state_d = S_WRITE;
				end
			end
			S_WRITE:  state_d = S_OUT;
			S_OUT:    if (out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// memory control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_SHIFT: begin
				if (act_q == ACT_ADD) begin
					// move entry idx-1 to idx, walking down
					ram_raddr = idx_q[AW-1:0] - AW'(1);
					ram_we    = rd_pend_q;
					ram_waddr = idx_q[AW-1:0];
				end else begin
					// move entry idx+1 to idx, walking up
					ram_raddr = idx_q[AW-1:0] + AW'(1);
					ram_we    = rd_pend_q;
					ram_waddr = idx_q[AW-1:0];
				end
			end
			S_WRITE: begin
				ram_we    = (act_q == ACT_ADD);
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = {tos_in_q, id_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_v_q   <= 1'b0;
			rd_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT && out_free) out_v_q <= 1'b1;
			else if (m_fire) out_v_q <= 1'b0;
			case (state_q)
				S_MOD: rd_pend_q <= 1'b0;
				S_SEARCH: begin
					if (scan_end) rd_pend_q <= 1'b0;
					else rd_pend_q <= !rd_pend_q;
				end
				S_DECIDE: rd_pend_q <= 1'b0;
				S_SHIFT: begin
					if (act_q == ACT_ADD) begin
						if (idx_q == pos_q) rd_pend_q <= 1'b0;
						else rd_pend_q <= !rd_pend_q;
					end else if (idx_q + CW'(1) >= cnt_q) begin
						rd_pend_q <= 1'b0;
					end else begin
						rd_pend_q <= !rd_pend_q;
					end
				end
				S_WRITE: begin
					if (act_q == ACT_ADD) cnt_q <= cnt_q + CW'(1);
					else cnt_q <= cnt_q - CW'(1);
				end
				S_OUT: begin
					if (act_q == ACT_CLEAR) cnt_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (s_fire) begin
				act_q    <= action_t'(s_axis_tdata[1:0]);
				tos_in_q <= s_axis_tdata[41:34];
			end
			S_MOD: if (mod_done) begin
				id_q    <= mod_rem;
				idx_q   <= '0;
				found_q <= 1'b0;
			end
			S_SEARCH: begin
				if (key_ge) begin
					pos_q     <= idx_q - CW'(1);
					found_q   <= (ram_rdata[31:0] == id_q);
					hit_tos_q <= ram_rdata[39:32];
				end else if (scan_end) begin
					pos_q <= idx_q;
				end else if (!rd_pend_q) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			S_DECIDE: begin
				st_q   <= ST_OK;
				hit_q  <= 1'b0;
				tout_q <= '0;
				idx_q  <= (act_q == ACT_ADD) ? cnt_q : pos_q;
				case (act_q)
					ACT_LOOKUP: begin
						if (cnt_q == '0) st_q <= ST_MISSING;
						else if (id_q < app_base_q) begin
							hit_q <= 1'b1; tout_q <= sys_tos_q;
						end else if (found_q) begin
							hit_q <= 1'b1; tout_q <= hit_tos_q;
						end else st_q <= ST_MISSING;
					end
					ACT_ADD: begin
						if (id_q < app_base_q) st_q <= ST_INVALID;
						else if (cnt_q >= FULL_CNT) st_q <= ST_FULL;
						else if (found_q) st_q <= ST_DUP;
					end
					ACT_DELETE: begin
						if (id_q < app_base_q) st_q <= ST_INVALID;
						else if (!found_q) st_q <= ST_MISSING;
					end
					default: ;
				endcase
			end
			S_SHIFT: begin
				if (rd_pend_q) begin
					if (act_q == ACT_ADD) idx_q <= idx_q - CW'(1);
					else idx_q <= idx_q + CW'(1);
				end
			end
			S_OUT: if (out_free) begin
				res_q <= {tout_q, hit_q, st_q};
			end
			default: ;
		endcase
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {4'd0, res_q};

`ifndef SYNTHESIS
	// the table never holds more than its depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT) else $error("entry count over depth");
	// a waiting result transaction holds still until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("waiting result changed");
	// count only moves when an item finishes its update, so never while idle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |=> $stable(cnt_q)) else $error("count moved in idle");
`endif

endmodule

// File: tb/uid_to_tos_sorted_table_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uid_to_tos_sorted_table_checker: result prediction for the sorted id table
// watches the input and output streams and the register writes, keeps a
// sorted copy of the table and compares every result transaction in order
// ----------------------------------------------------------------------------
module uid_to_tos_sorted_table_checker
	import utt_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [31:0] wr_data,
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		logic [7:0] tos_out;
		logic       tos_hit;
		status_t    status;
	} verdict_t;

	logic [31:0] app_base;
	logic [31:0] id_range;
	logic [7:0]  sys_tos;
	logic [31:0] keys [$];
	logic [7:0]  marks [$];
	verdict_t    verdicts [$];

	assign pending = verdicts.size();

	// first index whose key is not below the given id
	function automatic int find_slot(logic [31:0] id);
		int p;
		p = 0;
		while (p < keys.size() && keys[p] < id)
			p++;
		return p;
	endfunction

	function automatic verdict_t apply_item(action_t act, logic [31:0] raw,
		logic [7:0] tos);
		verdict_t v;
		logic [31:0] id;
		int p;
		bit found;
		v = '{status: ST_OK, tos_hit: 1'b0, tos_out: 8'd0};
		id = (id_range != 0) ? raw % id_range : raw;
		p = find_slot(id);
		found = p < keys.size() && keys[p] == id;
		case (act)
			ACT_LOOKUP: begin
				if (keys.size() == 0)
					v.status = ST_MISSING;
				else if (id < app_base) begin
					v.tos_hit = 1'b1;
					v.tos_out = sys_tos;
				end else if (found) begin
					v.tos_hit = 1'b1;
					v.tos_out = marks[p];
				end else
					v.status = ST_MISSING;
			end
			ACT_ADD: begin
				if (id < app_base)
					v.status = ST_INVALID;
				else if (keys.size() >= TABLE_DEPTH)
					v.status = ST_FULL;
				else if (found)
					v.status = ST_DUP;
				else begin
					keys.insert(p, id);
					marks.insert(p, tos);
				end
			end
			ACT_DELETE: begin
				if (id < app_base)
					v.status = ST_INVALID;
				else if (!found)
					v.status = ST_MISSING;
				else begin
					keys.delete(p);
					marks.delete(p);
				end
			end
			default: begin
				keys.delete();
				marks.delete();
			end
		endcase
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		verdict_t got, want;
		if (!arst_n) begin
			app_base = 32'd10000;
			id_range = 32'd100000;
			sys_tos = 8'd0;
			keys.delete();
			marks.delete();
			verdicts.delete();
			fail_count = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = verdict_t'(m_axis_tdata[11:0]);
				if (verdicts.size() == 0) begin
					$error("result transaction with nothing expected: %h", m_axis_tdata);
					fail_count++;
				end else begin
					want = verdicts.pop_front();
					if (got.status != want.status) begin
						$error("status: expected %0d actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.tos_hit != want.tos_hit) begin
						$error("tos_hit: expected %0d actual %0d", want.tos_hit, got.tos_hit);
						fail_count++;
					end
					if (got.tos_out != want.tos_out) begin
						$error("tos_out: expected %0d actual %0d", want.tos_out, got.tos_out);
						fail_count++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				verdicts.push_back(apply_item(action_t'(s_axis_tdata[1:0]),
					s_axis_tdata[33:2], s_axis_tdata[41:34]));
			if (wr_en) begin
				case (wr_index)
					REG_APP_BASE: app_base = wr_data;
					REG_RANGE:    id_range = wr_data;
					REG_SYS_TOS:  sys_tos = wr_data[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// File: tb/uid_to_tos_sorted_table_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uid_to_tos_sorted_table_top_tb: stimulus and verdict for the sorted id table
// directed and random lookup, add, delete and clear transactions over several
// register settings, with random idling on both streams and long stalls
// ----------------------------------------------------------------------------
module uid_to_tos_sorted_table_top_tb;
	import utt_pkg::*;

	localparam int unsigned DEPTH = 32;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned SETTLE = 400;   // worst item: remainder plus scan plus shift
	localparam int          HOLD_LEN = 3000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;    // action[1:0], raw_id[33:2], tos_value[41:34]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;    // status[2:0], tos_hit[3], tos_out[11:4]
	logic        wr_en;
	logic [1:0]  wr_index;
	logic [31:0] wr_data;
	int          fail_count;
	int          pending;

	// idling percentages of each side, and the long receiver hold-off
	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_cycles;
	logic        hold_tgl;        // flipped by the stimulus to ask for a hold-off
	logic        hold_seen;
	longint      cycle_count = 0;

	// shadow of the registers for choosing ids in range
	logic [31:0] cur_base;
	logic [31:0] cur_range;
	logic [31:0] known_ids [$];

	uid_to_tos_sorted_table_top #(.TABLE_DEPTH(DEPTH)) dut (.*);

	uid_to_tos_sorted_table_checker #(.TABLE_DEPTH(DEPTH)) checker_i (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
		.wr_en, .wr_index, .wr_data, .fail_count, .pending
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("uid_to_tos_sorted_table_top verification failed");
			$finish;
		end
	end

	// receiver side: random stalls, or a long hold-off when one is requested
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= 0;
			hold_seen <= 1'b0;
		end else if (hold_tgl != hold_seen) begin
			hold_seen <= hold_tgl;
			m_axis_tready <= 1'b0;
			hold_cycles <= HOLD_LEN;
		end else if (hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// one register write, block idle
	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		if (idx == REG_APP_BASE)
			cur_base = val;
		if (idx == REG_RANGE)
			cur_range = val;
	endtask

	// offer one transaction and hold it until accepted
	task automatic offer(action_t act, logic [31:0] raw, logic [7:0] tos);
		while ($urandom_range(99) < send_idle_pct) begin
			@(posedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, tos, raw, act};
		do
			@(posedge clk);
		while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
	endtask

	// wait for the last result, then let the block drain
	task automatic drain();
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// raw id that reduces to an application id where the range allows one, mostly from a small pool
	function automatic logic [31:0] pick_app_raw();
		logic [31:0] id;
		if (known_ids.size() > 0 && $urandom_range(2) != 0)
			return known_ids[$urandom_range(known_ids.size() - 1)];
		if (cur_range == 0 || cur_range > cur_base) begin
			id = cur_base + $urandom_range(60);
			if (cur_range != 0 && id >= cur_range)
				id = cur_range - 1;
			if (id < cur_base)
				id = cur_base;
			// aliased raw ids of the same root
			if (cur_range != 0 && $urandom_range(3) == 0)
				id = id + cur_range * $urandom_range(3);
		end else
			id = $urandom();
		if (known_ids.size() < 48)
			known_ids.push_back(id);
		return id;
	endfunction

	task automatic random_items(int count);
		action_t act;
		logic [31:0] raw;
		int r;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(99);
			if (r < 35)
				act = ACT_LOOKUP;
			else if (r < 70)
				act = ACT_ADD;
			else if (r < 95)
				act = ACT_DELETE;
			else
				act = ACT_CLEAR;
			raw = ($urandom_range(9) == 0) ? $urandom() : pick_app_raw();
			if ($urandom_range(9) == 0 && cur_base != 0)
				raw = $urandom_range(cur_base - 1);
			offer(act, raw, 8'($urandom()));
		end
	endtask

	task automatic setting(logic [31:0] base, logic [31:0] range, logic [7:0] stos);
		write_reg(2'(REG_APP_BASE), base);
		write_reg(2'(REG_RANGE), range);
		write_reg(2'(REG_SYS_TOS), stos);
		known_ids.delete();
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_tgl = 1'b0;
		cur_base = 32'd10000;
		cur_range = 32'd100000;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty-table lookups, rejects, sorted adds, deletes, clear
		offer(ACT_LOOKUP, 32'd5, 8'hff);              // empty table, system id
		offer(ACT_LOOKUP, 32'd20000, 8'h00);
		offer(ACT_DELETE, 32'd20000, 8'h00);          // not found
		offer(ACT_ADD, 32'd9999, 8'h11);              // below the base
		offer(ACT_DELETE, 32'd0, 8'h00);              // invalid delete
		offer(ACT_ADD, 32'd30000, 8'haa);
		offer(ACT_ADD, 32'd20000, 8'h55);             // goes in front
		offer(ACT_ADD, 32'd99999, 8'hff);
		offer(ACT_ADD, 32'd120000, 8'h01);            // aliases 20000: duplicate
		offer(ACT_LOOKUP, 32'd20000, 8'h00);
		offer(ACT_LOOKUP, 32'hffff_ffff, 8'h00);      // full-scale raw id
		offer(ACT_LOOKUP, 32'd100, 8'h00);            // system id, table in use
		offer(ACT_DELETE, 32'd30000, 8'h00);
		offer(ACT_LOOKUP, 32'd30000, 8'h00);
		offer(ACT_CLEAR, 32'hffff_ffff, 8'hff);
		offer(ACT_LOOKUP, 32'd99999, 8'h00);
		// fill the table to the brim and once more
		for (int i = 0; i <= DEPTH; i++)
			offer(ACT_ADD, 32'd50000 - 32'(i * 7), 8'(i));
		drain();

		// extremes: base 0 and zero modulus, all raw ids are applications
		setting(32'd0, 32'd0, 8'hff);
		offer(ACT_CLEAR, 32'd0, 8'd0);
		offer(ACT_ADD, 32'hffff_ffff, 8'h80);
		offer(ACT_ADD, 32'd0, 8'h7f);
		offer(ACT_LOOKUP, 32'hffff_ffff, 8'd0);
		offer(ACT_LOOKUP, 32'd0, 8'd0);
		random_items(150);
		drain();

		// top base, range 1: every root is 0, so all adds invalid
		setting(32'hffff_ffff, 32'd1, 8'h5a);
		random_items(50);
		drain();

		// phase with sender mostly flowing, receiver stalling hard
		setting(32'd1000, 32'd5000, 8'h3c);
		offer(ACT_CLEAR, 32'd0, 8'd0);
		send_idle_pct = 19;
		recv_idle_pct = 64;
		random_items(450);

		// long receiver hold-off while items keep coming
		hold_tgl = ~hold_tgl;
		random_items(30);
		drain();

		// the other way round
		send_idle_pct = 64;
		recv_idle_pct = 19;
		setting(32'd10000, 32'd100000, 8'h00);
		random_items(450);
		drain();

		// no idling, range at full scale
		send_idle_pct = 0;
		recv_idle_pct = 0;
		setting(32'h8000_0000, 32'hffff_ffff, 8'hc3);
		offer(ACT_CLEAR, 32'd0, 8'd0);
		random_items(500);
		drain();

		if (fail_count == 0)
			$display("uid_to_tos_sorted_table_top verification clean");
		else
			$display("uid_to_tos_sorted_table_top verification failed");
		$finish;
	end

endmodule
